// File: sv/rlpfx_pkg.sv
package rlpfx_pkg;

  localparam int LEN_BITS_DEF = 24;
  localparam int QDEPTH       = 2;
  localparam int WORD_COUNT   = 10;

  localparam logic [3:0] WORD_STATUS = 4'd0;
  localparam logic [3:0] WORD_NONCE  = 4'd1;
  localparam logic [3:0] WORD_CHAIN  = 4'd2;
  localparam logic [3:0] WORD_TO0    = 4'd3;
  localparam logic [3:0] WORD_TO1    = 4'd4;
  localparam logic [3:0] WORD_TO2    = 4'd5;
  localparam logic [3:0] WORD_VAL0   = 4'd6;
  localparam logic [3:0] WORD_VAL1   = 4'd7;
  localparam logic [3:0] WORD_VAL2   = 4'd8;
  localparam logic [3:0] WORD_VAL3   = 4'd9;
  localparam logic [3:0] WORD_LAST   = WORD_VAL3;

  localparam logic [7:0] HDR_SINGLE_MAX = 8'h7f;
  localparam logic [7:0] HDR_STR_BASE   = 8'h80;
  localparam logic [7:0] HDR_STR_MAX    = 8'hb7;
  localparam logic [7:0] HDR_LSTR_MAX   = 8'hbf;
  localparam logic [7:0] HDR_LIST_BASE  = 8'hc0;
  localparam logic [7:0] HDR_LIST_MAX   = 8'hf7;
  localparam logic [7:0] TYPE_MIN       = 8'h01;

  localparam logic [3:0] FIELD_MAX  = 4'd9;
  localparam int         TO_BYTES   = 20;
  localparam int         VAL_BYTES  = 32;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_OUTER_HDR,
    PH_OUTER_LEN,
    PH_FIELD_HDR,
    PH_FIELD_LEN,
    PH_FIELD_BODY,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_NONE,
    ROLE_NONCE,
    ROLE_CHAIN,
    ROLE_TO,
    ROLE_VALUE,
    ROLE_DATA
  } role_e;

  // one finished frame, ready for the emitter
  typedef struct packed {
    logic [63:0]  status;
    logic [63:0]  nonce;
    logic [63:0]  chain;
    logic [159:0] to_addr;
    logic [255:0] value;
  } summary_t;

  function automatic role_e role_of(input logic [6:0] typ, input logic [3:0] fld);
    role_e r;
    r = ROLE_NONE;
    if (typ == 7'd0) begin
      unique case (fld)
        4'd0:    r = ROLE_NONCE;
        4'd3:    r = ROLE_TO;
        4'd4:    r = ROLE_VALUE;
        4'd5:    r = ROLE_DATA;
        4'd6:    r = ROLE_CHAIN;
        default: r = ROLE_NONE;
      endcase
    end else begin
      unique case (fld)
        4'd0:    r = ROLE_CHAIN;
        4'd1:    r = ROLE_NONCE;
        4'd5:    r = ROLE_TO;
        4'd6:    r = ROLE_VALUE;
        4'd7:    r = ROLE_DATA;
        default: r = ROLE_NONE;
      endcase
    end
    return r;
  endfunction

endpackage

// File: sv/rlpfx_parser.sv
module rlpfx_parser #(
  parameter int LEN_BITS = rlpfx_pkg::LEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                push_o,
  output rlpfx_pkg::summary_t summary_o
);

  localparam int PW = LEN_BITS + 2;

  rlpfx_pkg::phase_e phase_q, phase_d;
  logic [LEN_BITS:0]   pos_q, pos_d;
  logic [6:0]          type_q, type_d;
  logic [PW-1:0]       oend_q, oend_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [3:0]          left_q, left_d;
  logic [PW-1:0]       cend_q, cend_d;
  logic [LEN_BITS-1:0] clen_q, clen_d;
  logic [3:0]          fld_q, fld_d;
  logic [63:0]         nonce_q, nonce_d;
  logic [63:0]         chain_q, chain_d;
  logic [19:0][7:0]    to_q, to_d;
  logic [31:0][7:0]    val_q, val_d;
  logic                has_to_q, has_to_d;
  logic [5:0]          amt_len_q, amt_len_d;
  logic [23:0]         pay_len_q, pay_len_d;
  logic                err_q, err_d;
  logic                done_q, done_d;

  logic [PW-1:0]       pos_ext, pos1, body_off, off, ll_end;
  logic [LEN_BITS-1:0] s_len, b_len;
  logic [PW-1:0]       s_start, b_end;
  logic                do_open, do_sized, do_begin, do_content, do_end, skip_b;
  logic                fits, ok;
  logic [32:0]         len_wide;
  logic [4:0]          val_idx;
  logic [3:0]          ll;
  rlpfx_pkg::phase_e   ph;
  rlpfx_pkg::role_e    role;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    type_d    = type_q;
    oend_d    = oend_q;
    acc_d     = acc_q;
    left_d    = left_q;
    cend_d    = cend_q;
    clen_d    = clen_q;
    fld_d     = fld_q;
    nonce_d   = nonce_q;
    chain_d   = chain_q;
    to_d      = to_q;
    val_d     = val_q;
    has_to_d  = has_to_q;
    amt_len_d = amt_len_q;
    pay_len_d = pay_len_q;
    err_d     = err_q;
    done_d    = done_q;

    pos_ext    = PW'(pos_q);
    pos1       = pos_ext + PW'(1);
    body_off   = PW'(clen_q) - (cend_q - pos_ext);
    off        = '0;
    s_len      = '0;
    s_start    = pos1;
    b_len      = '0;
    b_end      = pos1;
    ll         = '0;
    ll_end     = '0;
    do_open    = 1'b0;
    do_sized   = 1'b0;
    do_begin   = 1'b0;
    do_content = 1'b0;
    do_end     = 1'b0;
    skip_b     = 1'b0;
    ph         = phase_q;
    role       = rlpfx_pkg::ROLE_NONE;
    len_wide   = '0;
    val_idx    = '0;

    if (take_i) begin
      if (ph == rlpfx_pkg::PH_FIRST) begin
        ph      = rlpfx_pkg::PH_OUTER_HDR;
        phase_d = rlpfx_pkg::PH_OUTER_HDR;
        if (byte_i >= rlpfx_pkg::TYPE_MIN && byte_i <= rlpfx_pkg::HDR_SINGLE_MAX) begin
          type_d = byte_i[6:0];
          skip_b = 1'b1;
        end
      end

      if (!skip_b) begin
        unique case (ph)
          rlpfx_pkg::PH_OUTER_HDR: begin
            if (byte_i < rlpfx_pkg::HDR_LIST_BASE) begin
              err_d   = 1'b1;
              phase_d = rlpfx_pkg::PH_SKIP;
            end else if (byte_i <= rlpfx_pkg::HDR_LIST_MAX) begin
              do_open = 1'b1;
              s_len   = LEN_BITS'(byte_i - rlpfx_pkg::HDR_LIST_BASE);
            end else begin
              left_d  = 4'(byte_i - rlpfx_pkg::HDR_LIST_MAX);
              acc_d   = '0;
              phase_d = rlpfx_pkg::PH_OUTER_LEN;
            end
          end
          rlpfx_pkg::PH_OUTER_LEN, rlpfx_pkg::PH_FIELD_LEN: begin
            if (acc_q[LEN_BITS-1 -: 8] != 8'd0) begin
              err_d   = 1'b1;
              phase_d = rlpfx_pkg::PH_SKIP;
            end else begin
              acc_d  = LEN_BITS'({acc_q, byte_i});
              left_d = left_q - 4'd1;
              s_len  = acc_d;
              if (left_d == 4'd0) begin
                if (ph == rlpfx_pkg::PH_OUTER_LEN) do_open = 1'b1;
                else                               do_sized = 1'b1;
              end
            end
          end
          rlpfx_pkg::PH_FIELD_HDR: begin
            if (byte_i <= rlpfx_pkg::HDR_SINGLE_MAX) begin
              do_begin   = 1'b1;
              b_len      = LEN_BITS'(1);
              do_content = 1'b1;
              do_end     = 1'b1;
            end else if (byte_i <= rlpfx_pkg::HDR_STR_MAX) begin
              do_sized = 1'b1;
              s_len    = LEN_BITS'(byte_i - rlpfx_pkg::HDR_STR_BASE);
            end else if (byte_i >= rlpfx_pkg::HDR_LIST_BASE &&
                         byte_i <= rlpfx_pkg::HDR_LIST_MAX) begin
              do_sized = 1'b1;
              s_len    = LEN_BITS'(byte_i - rlpfx_pkg::HDR_LIST_BASE);
            end else begin
              ll = (byte_i <= rlpfx_pkg::HDR_LSTR_MAX) ?
                   4'(byte_i - rlpfx_pkg::HDR_STR_MAX) :
                   4'(byte_i - rlpfx_pkg::HDR_LIST_MAX);
              ll_end = pos1 + PW'(ll);
              if (ll_end > oend_q) begin
                err_d   = 1'b1;
                phase_d = rlpfx_pkg::PH_SKIP;
              end else begin
                left_d  = ll;
                acc_d   = '0;
                phase_d = rlpfx_pkg::PH_FIELD_LEN;
              end
            end
          end
          rlpfx_pkg::PH_FIELD_BODY: begin
            do_content = 1'b1;
            off        = body_off;
            if (pos1 >= cend_q) do_end = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // list opened: outer end and field counter
      if (do_open) begin
        oend_d = s_start + PW'(s_len);
        fld_d  = '0;
        if (s_len == '0) begin
          done_d  = 1'b1;
          phase_d = rlpfx_pkg::PH_SKIP;
        end else begin
          phase_d = rlpfx_pkg::PH_FIELD_HDR;
        end
      end

      // sized item: bounds check against the outer list
      if (do_sized) begin
        if (s_start + PW'(s_len) > oend_d) begin
          err_d   = 1'b1;
          phase_d = rlpfx_pkg::PH_SKIP;
        end else begin
          do_begin = 1'b1;
          b_len    = s_len;
          b_end    = s_start + PW'(s_len);
          if (s_len == '0) do_end = 1'b1;
          else             phase_d = rlpfx_pkg::PH_FIELD_BODY;
        end
      end

      role = rlpfx_pkg::role_of(type_d, fld_d);

      if (do_begin) begin
        cend_d   = b_end;
        clen_d   = b_len;
        len_wide = 33'(b_len);
        unique case (role)
          rlpfx_pkg::ROLE_NONCE: nonce_d = '0;
          rlpfx_pkg::ROLE_CHAIN: chain_d = '0;
          rlpfx_pkg::ROLE_TO:    if (len_wide == 33'(rlpfx_pkg::TO_BYTES)) has_to_d = 1'b1;
          rlpfx_pkg::ROLE_VALUE: begin
            if (len_wide <= 33'(rlpfx_pkg::VAL_BYTES)) amt_len_d = len_wide[5:0];
          end
          rlpfx_pkg::ROLE_DATA:  pay_len_d = (len_wide > 33'hFFFFFF) ? 24'hFFFFFF :
                                             len_wide[23:0];
          default: begin
          end
        endcase
      end

      if (do_content) begin
        len_wide = 33'(clen_d);
        val_idx  = off[4:0] - len_wide[4:0];
        unique case (role)
          rlpfx_pkg::ROLE_NONCE: if (off < PW'(8)) nonce_d = {nonce_d[55:0], byte_i};
          rlpfx_pkg::ROLE_CHAIN: if (off < PW'(8)) chain_d = {chain_d[55:0], byte_i};
          rlpfx_pkg::ROLE_TO: begin
            if (len_wide == 33'(rlpfx_pkg::TO_BYTES) && off < PW'(rlpfx_pkg::TO_BYTES))
              to_d[off[4:0]] = byte_i;
          end
          rlpfx_pkg::ROLE_VALUE: begin
            if (len_wide <= 33'(rlpfx_pkg::VAL_BYTES) && off < PW'(clen_d))
              val_d[val_idx] = byte_i;
          end
          default: begin
          end
        endcase
      end

      if (do_end) begin
        fld_d = fld_d + 4'd1;
        if (fld_d >= rlpfx_pkg::FIELD_MAX || cend_d >= oend_d) begin
          done_d  = 1'b1;
          phase_d = rlpfx_pkg::PH_SKIP;
        end else begin
          phase_d = rlpfx_pkg::PH_FIELD_HDR;
        end
      end

      // the type byte is not counted as an RLP position
      if (!skip_b && pos_q != '1) pos_d = pos_q + 1'b1;
    end
  end

  // summary built from the state after this byte
  always_comb begin
    fits = oend_d <= PW'(pos_d);
    ok   = !err_d && done_d && fits;
    summary_o = '0;
    summary_o.status = {8'd0, (fits ? pay_len_d : 24'd0), 10'd0,
                        (fits ? amt_len_d : 6'd0), 1'b0, type_d, 6'd0,
                        (fits & has_to_d), ok};
    if (fits) begin
      summary_o.nonce = nonce_d;
      summary_o.chain = chain_d;
      for (int k = 0; k < rlpfx_pkg::TO_BYTES; k++)
        summary_o.to_addr[159-8*k -: 8] = to_d[k];
      for (int k = 0; k < rlpfx_pkg::VAL_BYTES; k++)
        summary_o.value[255-8*k -: 8] = val_d[k];
    end
  end

  assign push_o = take_i & last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rlpfx_pkg::PH_FIRST;
      pos_q     <= '0;
      type_q    <= '0;
      oend_q    <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      cend_q    <= '0;
      clen_q    <= '0;
      fld_q     <= '0;
      nonce_q   <= '0;
      chain_q   <= '0;
      to_q      <= '0;
      val_q     <= '0;
      has_to_q  <= 1'b0;
      amt_len_q <= '0;
      pay_len_q <= '0;
      err_q     <= 1'b0;
      done_q    <= 1'b0;
    end else if (push_o) begin
      // frame done: back to the reset state for the next one
      phase_q   <= rlpfx_pkg::PH_FIRST;
      pos_q     <= '0;
      type_q    <= '0;
      oend_q    <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      cend_q    <= '0;
      clen_q    <= '0;
      fld_q     <= '0;
      nonce_q   <= '0;
      chain_q   <= '0;
      to_q      <= '0;
      val_q     <= '0;
      has_to_q  <= 1'b0;
      amt_len_q <= '0;
      pay_len_q <= '0;
      err_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      type_q    <= type_d;
      oend_q    <= oend_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      cend_q    <= cend_d;
      clen_q    <= clen_d;
      fld_q     <= fld_d;
      nonce_q   <= nonce_d;
      chain_q   <= chain_d;
      to_q      <= to_d;
      val_q     <= val_d;
      has_to_q  <= has_to_d;
      amt_len_q <= amt_len_d;
      pay_len_q <= pay_len_d;
      err_q     <= err_d;
      done_q    <= done_d;
    end
  end

endmodule

// File: sv/rlpfx_queue.sv
module rlpfx_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rlpfx_pkg::summary_t din_i,
  input  logic                pop_i,
  output rlpfx_pkg::summary_t dout_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int AW = $clog2(rlpfx_pkg::QDEPTH);

  rlpfx_pkg::summary_t mem_q [rlpfx_pkg::QDEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (AW+1)'(rlpfx_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign dout_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(rlpfx_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      cnt_d  = cnt_d + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(rlpfx_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      cnt_d  = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= din_i;
  end

endmodule

// File: sv/rlpfx_emitter.sv
module rlpfx_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  rlpfx_pkg::summary_t head_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [3:0]          index_o,
  output logic [63:0]         word_o,
  output logic                last_o
);

  logic [3:0] idx_q, idx_d;
  logic       fire;

  assign valid_o = avail_i;
  assign fire    = avail_i & ready_i;
  assign last_o  = idx_q == rlpfx_pkg::WORD_LAST;
  assign pop_o   = fire & last_o;
  assign index_o = idx_q;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = last_o ? rlpfx_pkg::WORD_STATUS : idx_q + 4'd1;
  end

  always_comb begin
    unique case (idx_q)
      rlpfx_pkg::WORD_STATUS: word_o = head_i.status;
      rlpfx_pkg::WORD_NONCE:  word_o = head_i.nonce;
      rlpfx_pkg::WORD_CHAIN:  word_o = head_i.chain;
      rlpfx_pkg::WORD_TO0:    word_o = head_i.to_addr[159:96];
      rlpfx_pkg::WORD_TO1:    word_o = head_i.to_addr[95:32];
      rlpfx_pkg::WORD_TO2:    word_o = {head_i.to_addr[31:0], 32'd0};
      rlpfx_pkg::WORD_VAL0:   word_o = head_i.value[255:192];
      rlpfx_pkg::WORD_VAL1:   word_o = head_i.value[191:128];
      rlpfx_pkg::WORD_VAL2:   word_o = head_i.value[127:64];
      rlpfx_pkg::WORD_VAL3:   word_o = head_i.value[63:0];
      default:                word_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= rlpfx_pkg::WORD_STATUS;
    else         idx_q <= idx_d;
  end

endmodule

// File: sv/rlp_transaction_field_extractor_unit.sv
// Output: a summary is queued on the edge that takes the last byte; word 0 shows
//   next cycle if the queue was empty, then one word per cycle while tready is high.
// Throughput: one byte per cycle unless both queue slots are taken; a frame leaves
//   as ten words, and the two-entry queue holds frames until the emitter drains them.
// Reset: rst_ni asynchronous, active low; parser, queue and emitter empty.
module rlp_transaction_field_extractor_unit #(
  parameter int LEN_BITS = rlpfx_pkg::LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [3:0] word_index, [67:4] word, [71:68] zero
  output logic        m_axis_tlast_o    // last_word
);

  rlpfx_pkg::summary_t sum_in, sum_head;
  logic take, push, pop, q_full, q_empty;
  logic [3:0]  idx;
  logic [63:0] word;

  // Front side stalls only when both summary slots are taken.
  assign s_axis_tready_o = !q_full;
  assign take            = s_axis_tvalid_i & s_axis_tready_o;

  // Front: RLP header walk, one byte per cycle unless q_full; snapshot on the last byte.
  rlpfx_parser #(.LEN_BITS(LEN_BITS)) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .byte_i    (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .push_o    (push),
    .summary_o (sum_in)
  );

  // Decouples parsing of the next frame from draining of this one.
  rlpfx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (sum_in),
    .pop_i   (pop),
    .dout_o  (sum_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: walks the ten words of the head summary.
  rlpfx_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!q_empty),
    .head_i  (sum_head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .index_o (idx),
    .word_o  (word),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, word, idx};

endmodule

// File: sv/rlpfx_checker.sv
module rlpfx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  a_last_on_final_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[3:0] == rlpfx_pkg::WORD_LAST) == m_axis_tlast_o))
    else $error("tlast does not match final word index");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && m_axis_tdata_o[3:0] == $past(m_axis_tdata_o[3:0]) + 4'd1))
    else $error("word index did not advance by one");

  a_restart_at_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
      (!m_axis_tvalid_o || m_axis_tdata_o[3:0] == rlpfx_pkg::WORD_STATUS))
    else $error("new summary does not start with status word");

  a_addr_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3:0] == rlpfx_pkg::WORD_TO2) |->
      (m_axis_tdata_o[35:4] == 32'd0 && m_axis_tdata_o[71:68] == 4'd0))
    else $error("address padding not zero");

  a_summary_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no summary pending after last request of a frame");

endmodule

bind rlp_transaction_field_extractor_unit rlpfx_checker u_rlpfx_checker (.*);

// File: tb/sv/rlpfx_summary_checker.sv
module rlpfx_summary_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [71:0] m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          frames_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlpfx_pkg::*;

  localparam int LB = LEN_BITS_DEF;
  localparam longint unsigned POS_SAT = (64'd1 << (LB + 1)) - 1;

  typedef struct {
    logic [3:0]  idx;
    logic [63:0] word;
    logic        last;
  } sum_word_t;

  sum_word_t summary_q[$];

  phase_e          ph;
  longint unsigned pos, list_end, len_acc, item_end, item_len, payload_len;
  int unsigned     len_left, fld, val_len;
  logic [6:0]      typ;
  logic [63:0]     nonce, chain;
  logic [7:0]      to_b[TO_BYTES];
  logic [7:0]      val_b[VAL_BYTES];
  logic            has_to, err, done;

  function automatic role_e field_role();
    if (fld >= 9) return ROLE_NONE;
    if (typ == 0) begin
      case (fld)
        0: return ROLE_NONCE;
        3: return ROLE_TO;
        4: return ROLE_VALUE;
        5: return ROLE_DATA;
        6: return ROLE_CHAIN;
        default: return ROLE_NONE;
      endcase
    end
    case (fld)
      0: return ROLE_CHAIN;
      1: return ROLE_NONCE;
      5: return ROLE_TO;
      6: return ROLE_VALUE;
      7: return ROLE_DATA;
      default: return ROLE_NONE;
    endcase
  endfunction

  task automatic clear_parser();
    ph = PH_FIRST; pos = 0; typ = 0; list_end = 0; len_acc = 0; len_left = 0;
    item_end = 0; item_len = 0; fld = 0; nonce = 0; chain = 0;
    foreach (to_b[i]) to_b[i] = 0;
    foreach (val_b[i]) val_b[i] = 0;
    has_to = 0; val_len = 0; payload_len = 0; err = 0; done = 0;
  endtask

  function automatic void abort_frame();
    err = 1; ph = PH_SKIP;
  endfunction

  // returns 1 once the final length byte is in
  function automatic bit take_len_byte(logic [7:0] b);
    if ((len_acc >> (LB - 8)) != 0) begin
      abort_frame();
      return 0;
    end
    len_acc = (len_acc << 8) | b;
    len_left--;
    return len_left == 0;
  endfunction

  task automatic open_list(longint unsigned st, longint unsigned ln);
    list_end = st + ln;
    fld = 0;
    if (ln == 0) begin
      done = 1; ph = PH_SKIP;
    end else begin
      ph = PH_FIELD_HDR;
    end
  endtask

  task automatic store_content(logic [7:0] b, longint unsigned off);
    case (field_role())
      ROLE_NONCE: if (off < 8) nonce = {nonce[55:0], b};
      ROLE_CHAIN: if (off < 8) chain = {chain[55:0], b};
      ROLE_TO: if (item_len == 20 && off < 20) to_b[off] = b;
      ROLE_VALUE: if (item_len <= 32 && off < item_len) val_b[(32 - item_len + off) & 31] = b;
      default: ;
    endcase
  endtask

  task automatic close_item();
    fld++;
    if (fld >= 9 || item_end >= list_end) begin
      done = 1; ph = PH_SKIP;
    end else begin
      ph = PH_FIELD_HDR;
    end
  endtask

  task automatic start_item(longint unsigned e, longint unsigned ln);
    item_end = e;
    item_len = ln;
    case (field_role())
      ROLE_NONCE: nonce = 0;
      ROLE_CHAIN: chain = 0;
      ROLE_TO: if (ln == 20) has_to = 1;
      ROLE_VALUE: if (ln <= 32) val_len = 32'(ln);
      ROLE_DATA: payload_len = (ln > 64'hFFFFFF) ? 64'hFFFFFF : ln;
      default: ;
    endcase
  endtask

  task automatic sized_item(longint unsigned st, longint unsigned ln);
    if (st + ln > list_end) begin
      abort_frame();
      return;
    end
    start_item(st + ln, ln);
    if (ln == 0) close_item();
    else ph = PH_FIELD_BODY;
  endtask

  task automatic parse_byte(logic [7:0] b);
    longint unsigned p;
    int unsigned ll;
    p = pos;
    if (ph == PH_FIRST) begin
      ph = PH_OUTER_HDR;
      if (b >= TYPE_MIN && b <= HDR_SINGLE_MAX) begin
        // type byte: not an RLP position
        typ = b[6:0];
        return;
      end
    end
    case (ph)
      PH_OUTER_HDR: begin
        if (b < HDR_LIST_BASE) abort_frame();
        else if (b <= HDR_LIST_MAX) open_list(p + 1, b - HDR_LIST_BASE);
        else begin
          len_left = b - HDR_LIST_MAX; len_acc = 0; ph = PH_OUTER_LEN;
        end
      end
      PH_OUTER_LEN: if (take_len_byte(b)) open_list(p + 1, len_acc);
      PH_FIELD_HDR: begin
        if (b <= HDR_SINGLE_MAX) begin
          start_item(p + 1, 1);
          store_content(b, 0);
          close_item();
        end else if (b <= HDR_STR_MAX || (b >= HDR_LIST_BASE && b <= HDR_LIST_MAX)) begin
          sized_item(p + 1, b - ((b < HDR_LIST_BASE) ? HDR_STR_BASE : HDR_LIST_BASE));
        end else begin
          ll = b - ((b < HDR_LIST_BASE) ? HDR_STR_MAX : HDR_LIST_MAX);
          if (p + 1 + ll > list_end) abort_frame();
          else begin
            len_left = ll; len_acc = 0; ph = PH_FIELD_LEN;
          end
        end
      end
      PH_FIELD_LEN: if (take_len_byte(b)) sized_item(p + 1, len_acc);
      PH_FIELD_BODY: begin
        store_content(b, item_len - (item_end - p));
        if (p + 1 >= item_end) close_item();
      end
      default: ;
    endcase
    if (pos < POS_SAT) pos++;
  endtask

  function automatic logic [63:0] pack8(logic [7:0] a[], int base, int n);
    logic [63:0] v;
    v = 0;
    for (int i = 0; i < 8; i++) v = {v[55:0], (i < n) ? a[base + i] : 8'h00};
    return v;
  endfunction

  task automatic queue_summary();
    logic [63:0] w[WORD_COUNT];
    logic fits, ok;
    sum_word_t e;
    fits = list_end <= pos;
    ok = !err && done && fits;
    foreach (w[i]) w[i] = 0;
    w[WORD_STATUS] = {48'd0, 1'b0, typ, 7'd0, ok};
    if (fits) begin
      w[WORD_STATUS][1] = has_to;
      w[WORD_STATUS][21:16] = val_len[5:0];
      w[WORD_STATUS][55:32] = payload_len[23:0];
      w[WORD_NONCE] = nonce;
      w[WORD_CHAIN] = chain;
      w[WORD_TO0] = pack8(to_b, 0, 8);
      w[WORD_TO1] = pack8(to_b, 8, 8);
      w[WORD_TO2] = pack8(to_b, 16, 4);
      for (int k = 0; k < 4; k++) w[WORD_VAL0 + k] = pack8(val_b, 8 * k, 8);
    end
    for (int k = 0; k < WORD_COUNT; k++) begin
      e.idx = 4'(k); e.word = w[k]; e.last = (k == WORD_COUNT - 1);
      summary_q.push_back(e);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    frames_o = 0;
    pending_o = 0;
    clear_parser();
  end

  always @(posedge clk_i) begin
    sum_word_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (summary_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_axis_tdata_i));
        end else begin
          e = summary_q.pop_front();
          if (m_axis_tdata_i[3:0] != e.idx)
            report_mismatch($sformatf("index %0d, want %0d", m_axis_tdata_i[3:0], e.idx));
          if (m_axis_tdata_i[67:4] != e.word)
            report_mismatch($sformatf("word %0d = %h, want %h", e.idx,
                                      m_axis_tdata_i[67:4], e.word));
          if (m_axis_tdata_i[71:68] != 4'd0) report_mismatch("pad bits not zero");
          if (m_axis_tlast_i != e.last)
            report_mismatch($sformatf("tlast %b on word %0d", m_axis_tlast_i, e.idx));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_byte(s_axis_tdata_i);
        if (s_axis_tlast_i) begin
          queue_summary();
          frames_o++;
          clear_parser();
        end
      end
      pending_o = summary_q.size();
    end
  end
endmodule

// File: tb/sv/tb_rlp_transaction_field_extractor_unit.sv
module tb_rlp_transaction_field_extractor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rlpfx_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int  fail_count, pending, frames;
  int  byte_count = 0;
  int  idle_cycles = 0;
  bit  calm = 0;        // no idling near the end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rlp_transaction_field_extractor_unit dut (.*);

  rlpfx_summary_checker u_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .frames_o(frames)
  );

  // receiver: bursts of stall, bursts of readiness
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = int'($urandom_range(1, 10));
      m_axis_tready_i <= calm || $urandom_range(0, 2) != 0;
      repeat (n) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no accepted request or word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one request per handshake; sender may idle before it
  task automatic send_byte(logic [7:0] b, logic l);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    byte_count++;
  endtask

  task automatic send_frame(logic [7:0] f[$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // RLP string of len random bytes
  function automatic void rlp_str(ref logic [7:0] q[$], input int len);
    if (len == 1 && $urandom_range(0, 1)) begin
      q.push_back(8'($urandom_range(0, 127)));
      return;
    end
    if (len <= 55) q.push_back(8'(HDR_STR_BASE + len));
    else if (len < 256) begin
      q.push_back(8'(HDR_STR_MAX + 1)); q.push_back(8'(len));
    end else begin
      q.push_back(8'(HDR_STR_MAX + 2)); q.push_back(8'(len >> 8)); q.push_back(len[7:0]);
    end
    repeat (len) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // random transaction, mostly well formed
  function automatic void make_tx(ref logic [7:0] f[$]);
    logic [7:0] body[$];
    int lens[9] = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    int nf, blen;
    bit typed;
    typed = 1'($urandom_range(0, 1));
    nf = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 12)) : 9;
    for (int i = 0; i < nf; i++) begin
      case ($urandom_range(0, 6))
        0: lens[i % 9] = 0;
        1: lens[i % 9] = 1;
        2: lens[i % 9] = 20;
        3: lens[i % 9] = 32;
        4: lens[i % 9] = int'($urandom_range(2, 24));
        5: lens[i % 9] = $urandom_range(0, 9) == 0 ? int'($urandom_range(56, 60)) : 8;
        default: lens[i % 9] = int'($urandom_range(0, 12));
      endcase
      if (i % 9 == 7 && $urandom_range(0, 3) == 0) begin
        body.push_back(8'(HDR_LIST_BASE + 2)); body.push_back(8'h81); body.push_back(8'hff);
      end else begin
        rlp_str(body, lens[i % 9]);
      end
    end
    blen = body.size();
    if ($urandom_range(0, 7) == 0) blen = blen + int'($urandom_range(0, 6)) - 3;
    if (blen < 0) blen = 0;
    if (typed) f.push_back(8'($urandom_range(1, 127)));
    if (blen <= 55) f.push_back(8'(HDR_LIST_BASE + blen));
    else if (blen < 256) begin
      f.push_back(8'(HDR_LIST_MAX + 1)); f.push_back(8'(blen));
    end else begin
      f.push_back(8'(HDR_LIST_MAX + 2)); f.push_back(8'(blen >> 8)); f.push_back(blen[7:0]);
    end
    foreach (body[i]) f.push_back(body[i]);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) f.push_back(8'($urandom()));
    if ($urandom_range(0, 9) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
  endfunction

  initial begin
    logic [7:0] f[$];
    int frame_no;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge cases of the header decode
    send_frame('{8'h00});                              // lone zero, no list
    send_frame('{8'hff});                              // long list, frame ends in header
    send_frame('{8'h7f, 8'hc0});                       // max type, empty list
    send_frame('{8'h01, 8'h80});                       // string where list expected
    send_frame('{8'hc3, 8'h81, 8'h05, 8'h00});         // string and byte fill the list
    send_frame('{8'hc2, 8'hb9, 8'hff});                // long item header past list end
    send_frame('{8'hfb, 8'h00, 8'h00, 8'h00, 8'h01});  // 4-byte length, list past end
    send_frame('{8'hc1, 8'h82});                       // item overruns list
    send_frame('{8'hc1, 8'h2a, 8'hde, 8'had});         // trailing bytes ignored

    // pause until every summary has drained
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    frame_no = 0;
    while (byte_count < 120 && frame_no < 120) begin
      if (byte_count >= 95) calm = 1;
      f.delete();
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 12)) f.push_back(8'($urandom()));
      else make_tx(f);
      if (f.size() == 0) f.push_back(8'($urandom()));
      if (f.size() > 80) f = f[0:79];
      send_frame(f);
      frame_no++;
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes in %0d frames: typed and legacy layouts, long headers,",
             byte_count, frames);
    $display("truncated and overrun lists, with random idling on both sides.");
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: rlp_transaction_field_extractor_unit.f
sv/rlpfx_pkg.sv
sv/rlpfx_parser.sv
sv/rlpfx_queue.sv
sv/rlpfx_emitter.sv
sv/rlp_transaction_field_extractor_unit.sv
sv/rlpfx_checker.sv
tb/sv/rlpfx_summary_checker.sv
tb/sv/tb_rlp_transaction_field_extractor_unit.sv
